// ===== hdl/sefr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sefr_pkg
// Shared types and constants for the start/end delimited frame receiver.
// ----------------------------------------------------------------------------
package sefr_pkg;

    localparam int PAYLOAD_DEPTH = 32;
    localparam int PTR_W         = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int CNT_W         = $clog2(PAYLOAD_DEPTH + 1);
    localparam int BYTE_W        = 8;
    localparam int IDX_W         = 5;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 1'd1;

    localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'd1;
    localparam logic [BYTE_W-1:0] END_BYTE_RESET   = 8'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_LEN,
        ST_PAY,
        ST_READ,
        ST_LOAD
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_cmd;
        logic load_len;
        logic wr_payload;
        logic set_ovf;
        logic rst_k;
        logic rd_issue;
        logic inc_k;
        logic load_out;
        logic clear_frame;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_start;
        logic is_end;
        logic is_zero;
        logic count_full;
        logic last_k;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== hdl/soh_eot_frame_receiver.sv =====
`timescale 1ns / 1ps
// Header and payload bytes are taken as they arrive. The end byte starts a buffer walk
// whose first result is read in ST_READ and registered in ST_LOAD once the result
// register has room. Throughput: outside the walk one byte per cycle; the walk reads
// the RAM, then loads the result register, for each result, and stalls input
// throughout, an empty frame giving one result. Reset: synchronous, active low;
// delimiters return to 0x01/0x04, frame state clears; the payload buffer is left as is.
// ----------------------------------------------------------------------------
// soh_eot_frame_receiver
// Receives start/command/length/payload/end frames and gives out the payload
// as a run of results tagged with the frame header (one empty result for an empty frame).
// ----------------------------------------------------------------------------
module soh_eot_frame_receiver
    import sefr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [BYTE_W-1:0]    o_frame_command,
    output logic [BYTE_W-1:0]    o_frame_length,
    output logic [BYTE_W-1:0]    o_payload_byte,
    output logic [IDX_W-1:0]     o_payload_index,
    output logic                 o_last_of_frame,
    output logic                 o_frame_empty,
    output logic                 o_frame_overflow
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    sefr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_stall (o_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    sefr_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_rx_byte        (i_rx_byte),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_out_stall      (i_stall),
        .o_out_valid      (o_valid),
        .o_frame_command  (o_frame_command),
        .o_frame_length   (o_frame_length),
        .o_payload_byte   (o_payload_byte),
        .o_payload_index  (o_payload_index),
        .o_last_of_frame  (o_last_of_frame),
        .o_frame_empty    (o_frame_empty),
        .o_frame_overflow (o_frame_overflow)
    );

endmodule

// ===== hdl/sefr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sefr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sefr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/sefr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sefr_datapath
// Delimiter registers, frame header hold, payload buffer and result register.
// ----------------------------------------------------------------------------
module sefr_datapath
    import sefr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [BYTE_W-1:0]    o_frame_command,
    output logic [BYTE_W-1:0]    o_frame_length,
    output logic [BYTE_W-1:0]    o_payload_byte,
    output logic [IDX_W-1:0]     o_payload_index,
    output logic                 o_last_of_frame,
    output logic                 o_frame_empty,
    output logic                 o_frame_overflow
);

    logic [BYTE_W-1:0] r_start_byte;
    logic [BYTE_W-1:0] r_end_byte;
    logic [BYTE_W-1:0] r_cmd;
    logic [BYTE_W-1:0] r_len;
    logic [CNT_W-1:0]  r_count;
    logic              r_ovf;
    logic [PTR_W-1:0]  r_k;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_cmd;
    logic [BYTE_W-1:0] r_out_len;
    logic [BYTE_W-1:0] r_out_byte;
    logic [IDX_W-1:0]  r_out_idx;
    logic              r_out_last;
    logic              r_out_empty;
    logic              r_out_ovf;

    logic [BYTE_W-1:0] ram_rdata;
    logic              count_zero;

    sefr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PAYLOAD_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_payload),
        .i_waddr (r_count[PTR_W-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_k),
        .o_rdata (ram_rdata)
    );

    assign count_zero        = (r_count == '0);
    assign o_stat.is_start   = (i_rx_byte == r_start_byte);
    assign o_stat.is_end     = (i_rx_byte == r_end_byte);
    assign o_stat.is_zero    = (i_rx_byte == '0);
    assign o_stat.count_full = (r_count == CNT_W'(PAYLOAD_DEPTH));
    // An empty frame gives its single result as the last one.
    assign o_stat.last_k     = count_zero || ((CNT_W'(r_k) + 1'b1) == r_count);
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RESET;
            r_end_byte   <= END_BYTE_RESET;
            r_cmd        <= '0;
            r_len        <= '0;
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_k          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_START_BYTE: r_start_byte <= i_cfg_data;
                    CFG_END_BYTE:   r_end_byte   <= i_cfg_data;
                    default:        ;
                endcase
            end
            if (i_cmd.load_cmd) begin
                r_cmd <= i_rx_byte;
            end
            if (i_cmd.load_len) begin
                r_len <= i_rx_byte;
            end
            if (i_cmd.wr_payload) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.rst_k) begin
                r_k <= '0;
            end else if (i_cmd.inc_k) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.clear_frame) begin
                r_cmd   <= '0;
                r_len   <= '0;
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_cmd   <= r_cmd;
            r_out_len   <= r_len;
            r_out_byte  <= count_zero ? '0 : ram_rdata;
            r_out_idx   <= count_zero ? '0 : IDX_W'(r_k);
            r_out_last  <= o_stat.last_k;
            r_out_empty <= count_zero;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_frame_command  = r_out_cmd;
    assign o_frame_length   = r_out_len;
    assign o_payload_byte   = r_out_byte;
    assign o_payload_index  = r_out_idx;
    assign o_last_of_frame  = r_out_last;
    assign o_frame_empty    = r_out_empty;
    assign o_frame_overflow = r_out_ovf;

endmodule

// ===== hdl/sefr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sefr_ctrl
// Frame phase sequencer and end-of-frame buffer walk.
// ----------------------------------------------------------------------------
module sefr_ctrl
    import sefr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   in_xfer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state == ST_READ) || (r_state == ST_LOAD);
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && i_stat.is_start) begin
                    n_state = ST_CMD;
                end
            end
            ST_CMD: begin
                if (in_xfer && !i_stat.is_start) begin
                    o_cmd.load_cmd = 1'b1;
                    if (!i_stat.is_zero) begin
                        n_state = ST_LEN;
                    end
                end
            end
            ST_LEN: begin
                if (in_xfer && !i_stat.is_start) begin
                    o_cmd.load_len = 1'b1;
                    if (!i_stat.is_zero) begin
                        n_state = ST_PAY;
                    end
                end
            end
            ST_PAY: begin
                // The start test comes first, so a start byte never ends a frame.
                if (in_xfer && !i_stat.is_start) begin
                    if (i_stat.is_end) begin
                        o_cmd.rst_k = 1'b1;
                        n_state     = ST_READ;
                    end else if (i_stat.count_full) begin
                        o_cmd.set_ovf = 1'b1;
                    end else begin
                        o_cmd.wr_payload = 1'b1;
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = ST_LOAD;
            end
            ST_LOAD: begin
                // Read data holds until the result register has room for it.
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (i_stat.last_k) begin
                        o_cmd.clear_frame = 1'b1;
                        n_state           = ST_IDLE;
                    end else begin
                        o_cmd.inc_k = 1'b1;
                        n_state     = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
